// ===== src/atm_pkg.sv =====
// shared types, codes, character constants and helpers of the at command front end
package atm_pkg;

    localparam int LINE_DEPTH_DEF = 40;
    localparam int PFX_N          = 5;
    localparam int PFX_IW         = 3;
    localparam int S_TDATA_W      = 8;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 24;
    localparam int M_TUSER_W      = 3;
    localparam int CFG_W          = 20;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_RING      = 2'd1,
        OP_LINK_UP   = 2'd2,
        OP_LINK_DOWN = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ECHO    = 3'd0,
        KIND_RESP    = 3'd1,
        KIND_DIAL    = 3'd2,
        KIND_NET     = 3'd3,
        KIND_HANGUP  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        RESP_OK      = 3'd0,
        RESP_ERROR   = 3'd1,
        RESP_RING    = 3'd2,
        RESP_CONNECT = 3'd3,
        RESP_VERIFY  = 3'd4
    } resp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_SPEED = 2'd0,
        REG_CARRIER    = 2'd1,
        REG_ESCAPE     = 2'd2,
        REG_BACKSPACE  = 2'd3
    } reg_idx_t;

    localparam logic [1:0] POL_INVERTED = 2'd0;
    localparam logic [1:0] POL_DIRECT   = 2'd1;

    localparam logic [4:0] CODE_NONE  = 5'd0;
    localparam logic [4:0] CODE_RING  = 5'd2;
    localparam logic [4:0] CODE_ERROR = 5'd4;

    localparam logic [19:0] RST_LINE_SPEED = 20'd9600;
    localparam logic [7:0]  RST_ESCAPE     = 8'h2B;
    localparam logic [7:0]  RST_BACKSPACE  = 8'h08;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [PFX_N-1:0][7:0] pfx_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic decode;
        logic scan;
        logic emit;
    } atm_cmd_t;

    typedef struct packed {
        logic need_run;
        logic need_scan;
        logic scan_done;
        logic pending;
    } atm_stat_t;

    function automatic logic [4:0] speed_code(input logic [19:0] spd, input logic answering);
        logic [4:0] code;
        case (spd)
            20'd38400: code = 5'd28;
            20'd19200: code = answering ? 5'd14 : 5'd15;
            20'd14400: code = 5'd13;
            20'd9600:  code = 5'd12;
            20'd4800:  code = 5'd11;
            20'd2400:  code = 5'd10;
            20'd1200:  code = 5'd5;
            default:   code = 5'd1;
        endcase
        return code;
    endfunction

endpackage

// ===== src/atm_ctrl.sv =====
// sequencing state machine of the at command front end
module atm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output atm_pkg::atm_cmd_t cmd,
    input  atm_pkg::atm_stat_t stat
);
    import atm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_STEP;
            ST_STEP:   state_next = stat.need_run ? ST_DECODE : ST_EMIT;
            ST_DECODE: state_next = stat.need_scan ? ST_SCAN : ST_EMIT;
            ST_SCAN:   if (stat.scan_done) state_next = ST_EMIT;
            ST_EMIT:   if (!stat.pending) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.step   = (state_reg == ST_STEP);
    assign cmd.decode = (state_reg == ST_DECODE);
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.emit   = (state_reg == ST_EMIT);

endmodule

// ===== src/atm_dp.sv =====
// datapath: line memory, mode flags, command decode, flag scan and output register
module atm_dp #(
    parameter int LINE_DEPTH = atm_pkg::LINE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  atm_pkg::atm_cmd_t               cmd,
    output atm_pkg::atm_stat_t              stat,
    input  logic [atm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [atm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            cfg_we,
    input  logic [atm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atm_pkg::CFG_W-1:0]       cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [atm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [atm_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import atm_pkg::*;

    localparam int IW = $clog2(LINE_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(2 * LINE_DEPTH);

    function automatic logic [AW-1:0] maddr(input logic bank, input logic [IW-1:0] idx);
        return AW'(idx) + (bank ? AW'(LINE_DEPTH) : AW'(0));
    endfunction

    // configuration
    logic [19:0] speed_reg;
    logic [1:0]  pol_reg;
    logic [7:0]  esc_reg, bs_reg;

    // line state
    logic [7:0]    mem [0:2*LINE_DEPTH-1];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr, rd_addr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    logic          cur_bank_reg, cur_bank_next, prev_bank_reg, prev_bank_next;
    logic [LW-1:0] len_reg, len_next, prev_len_reg, prev_len_next;
    pfx_t          cur_pfx_reg, cur_pfx_next, prev_pfx_reg, prev_pfx_next;
    logic          prev_atf_reg, prev_atf_next;
    logic [1:0]    run_reg, run_next;
    logic          cmd_f_reg, cmd_f_next, conn_f_reg, conn_f_next, ring_f_reg, ring_f_next;
    logic          echo_f_reg, echo_f_next, wordy_f_reg, wordy_f_next;
    logic          auto_f_reg, auto_f_next;

    // item and pending results
    logic [1:0]    op_reg, op_next;
    logic [7:0]    byte_reg, byte_next;
    logic          a_slash_reg, a_slash_next;
    logic          pulse_reg, pulse_next;
    logic          echo_p_reg, echo_p_next, ok_p_reg, ok_p_next, main_p_reg, main_p_next;
    logic [7:0]    echo_byte_reg, echo_byte_next, main_byte_reg, main_byte_next;
    kind_t         main_kind_reg, main_kind_next;
    resp_t         main_resp_reg, main_resp_next;
    logic [4:0]    main_code_reg, main_code_next;
    logic [LW-1:0] dial_idx_reg, dial_idx_next, dial_end_reg, dial_end_next;

    // flag scan
    logic [LW-1:0] scan_idx_reg, scan_idx_next;
    logic          scan_v_reg, scan_v_next;
    logic [7:0]    b1_reg, b1_next, b2_reg, b2_next;
    logic          e0_reg, e0_next, e1_reg, e1_next, q0_reg, q0_next;
    logic          v0_reg, v0_next, v1_reg, v1_next;
    logic          s0_reg, s0_next, dig_reg, dig_next, nz_reg, nz_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    // combinational helpers
    logic [7:0]    c, esc_src;
    logic [1:0]    run_inc;
    logic          trig;
    pfx_t          pfx_new;
    logic [LW-1:0] len_new;
    logic          use_prev, xb, p_at;
    logic [LW-1:0] xl;
    pfx_t          xp;
    logic          is_atz, is_atf, is_ata, is_atdo, st_atdt, st_dtsp, st_dsp, is_ath, st_at;
    logic          dial_p, dial_rdy, out_free, carrier;
    logic [7:0]    x;

    assign c       = (byte_reg >= CH_LA && byte_reg <= CH_LZ) ? byte_reg - CASE_OFS : byte_reg;
    assign esc_src = cmd_f_reg ? c : byte_reg;
    assign run_inc = (esc_src == esc_reg) ? run_reg + 2'd1 : 2'd0;
    assign trig    = (run_inc == 2'd3);

    assign use_prev = a_slash_reg || (len_reg == LW'(3) && cur_pfx_reg[0] == CH_A
                      && cur_pfx_reg[1] == CH_T && cur_pfx_reg[2] == CH_SLASH);
    assign xb   = use_prev ? prev_bank_reg : cur_bank_reg;
    assign xl   = use_prev ? prev_len_reg : len_reg;
    assign xp   = use_prev ? prev_pfx_reg : cur_pfx_reg;
    assign p_at = xp[0] == CH_A && xp[1] == CH_T;
    assign is_atz  = xl == LW'(3) && p_at && xp[2] == CH_Z;
    assign is_atf  = xl == LW'(4) && p_at && xp[2] == CH_AMP && xp[3] == CH_F;
    assign is_ata  = xl == LW'(3) && p_at && xp[2] == CH_A;
    assign is_atdo = xl == LW'(3) && p_at && (xp[2] == CH_D || xp[2] == CH_O);
    assign st_atdt = xl >= LW'(4) && p_at && xp[2] == CH_D && xp[3] == CH_T;
    assign st_dtsp = xl >= LW'(5) && p_at && xp[2] == CH_D && (xp[3] == CH_T || xp[3] == CH_P)
                     && xp[4] == CH_SP;
    assign st_dsp  = xl >= LW'(4) && p_at && xp[2] == CH_D && xp[3] == CH_SP;
    assign is_ath  = p_at && xp[2] == CH_H && (xl == LW'(3) || (xl == LW'(4) && xp[3] == CH_0));
    assign st_at   = xl >= LW'(2) && p_at;

    assign dial_p   = dial_idx_reg < dial_end_reg;
    assign rd_addr  = cmd.scan ? maddr(prev_bank_reg, scan_idx_reg[IW-1:0])
                               : maddr(prev_bank_reg, dial_idx_reg[IW-1:0]);
    assign dial_rdy = (rd_addr_reg == rd_addr);
    assign out_free = !m_valid_reg || m_tready;
    assign x        = rdata_reg;
    assign carrier  = (pol_reg == POL_INVERTED) ? !conn_f_reg
                    : (pol_reg == POL_DIRECT) ? conn_f_reg : 1'b0;

    always_comb begin
        cur_bank_next  = cur_bank_reg;   prev_bank_next = prev_bank_reg;
        len_next       = len_reg;        prev_len_next  = prev_len_reg;
        cur_pfx_next   = cur_pfx_reg;    prev_pfx_next  = prev_pfx_reg;
        prev_atf_next  = prev_atf_reg;   run_next       = run_reg;
        cmd_f_next     = cmd_f_reg;      conn_f_next    = conn_f_reg;
        ring_f_next    = ring_f_reg;     echo_f_next    = echo_f_reg;
        wordy_f_next   = wordy_f_reg;    auto_f_next    = auto_f_reg;
        op_next        = op_reg;         byte_next      = byte_reg;
        a_slash_next   = a_slash_reg;    pulse_next     = pulse_reg;
        echo_p_next    = echo_p_reg;     ok_p_next      = ok_p_reg;
        main_p_next    = main_p_reg;     echo_byte_next = echo_byte_reg;
        main_byte_next = main_byte_reg;  main_kind_next = main_kind_reg;
        main_resp_next = main_resp_reg;  main_code_next = main_code_reg;
        dial_idx_next  = dial_idx_reg;   dial_end_next  = dial_end_reg;
        scan_idx_next  = scan_idx_reg;   scan_v_next    = 1'b0;
        b1_next = b1_reg; b2_next = b2_reg;
        e0_next = e0_reg; e1_next = e1_reg; q0_next = q0_reg;
        v0_next = v0_reg; v1_next = v1_reg;
        s0_next = s0_reg; dig_next = dig_reg; nz_next = nz_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        mem_we  = 1'b0;
        mem_wa  = maddr(cur_bank_reg, len_reg[IW-1:0]);
        pfx_new = cur_pfx_reg;
        len_new = len_reg;
        stat.need_run  = 1'b0;
        stat.need_scan = 1'b0;
        stat.scan_done = 1'b0;
        stat.pending   = echo_p_reg || ok_p_reg || main_p_reg || dial_p;

        if (cmd.accept) begin
            op_next       = s_tuser;
            byte_next     = s_tdata;
            a_slash_next  = 1'b0;
            pulse_next    = 1'b0;
            echo_p_next   = 1'b0;
            ok_p_next     = 1'b0;
            main_p_next   = 1'b0;
            dial_idx_next = '0;
            dial_end_next = '0;
        end

        if (cmd.step) begin
            main_byte_next = '0;
            main_code_next = CODE_NONE;
            main_resp_next = RESP_OK;
            case (op_reg)
                OP_BYTE: begin
                    if (cmd_f_reg) begin
                        echo_p_next    = echo_f_reg;
                        echo_byte_next = c;
                        run_next       = trig ? 2'd0 : run_inc;
                        ok_p_next      = trig;
                        if (c == bs_reg) begin
                            if (len_reg != '0) len_next = len_reg - LW'(1);
                        end else if (c != CH_CR && c != CH_LF && c != esc_reg) begin
                            if (len_reg < LW'(LINE_DEPTH)) begin
                                mem_we = 1'b1;
                                if (len_reg < LW'(PFX_N)) pfx_new[len_reg[PFX_IW-1:0]] = c;
                                len_new = len_reg + LW'(1);
                            end
                            cur_pfx_next = pfx_new;
                            len_next     = len_new;
                            if (len_new >= LW'(2) && pfx_new[0] == CH_A
                                && pfx_new[1] == CH_SLASH) begin
                                stat.need_run = 1'b1;
                                a_slash_next  = 1'b1;
                            end
                        end else if (len_reg >= LW'(2) && cur_pfx_reg[0] == CH_A
                                     && cur_pfx_reg[1] == CH_T) begin
                            stat.need_run = 1'b1;
                        end else begin
                            len_next = '0;
                        end
                    end else if (conn_f_reg) begin
                        echo_p_next    = echo_f_reg;
                        echo_byte_next = byte_reg;
                        run_next       = trig ? 2'd0 : run_inc;
                        ok_p_next      = trig;
                        if (trig) begin
                            cmd_f_next = 1'b1;
                        end else begin
                            main_p_next    = 1'b1;
                            main_kind_next = KIND_NET;
                            main_byte_next = byte_reg;
                        end
                    end
                end
                OP_RING: begin
                    main_p_next    = 1'b1;
                    main_kind_next = KIND_RESP;
                    if (auto_f_reg) begin
                        conn_f_next    = 1'b1;
                        cmd_f_next     = 1'b0;
                        ring_f_next    = 1'b0;
                        main_resp_next = RESP_CONNECT;
                        main_code_next = speed_code(speed_reg, 1'b1);
                    end else begin
                        ring_f_next    = 1'b1;
                        main_resp_next = RESP_RING;
                        main_code_next = CODE_RING;
                        pulse_next     = 1'b1;
                    end
                end
                OP_LINK_UP: begin
                    conn_f_next    = 1'b1;
                    cmd_f_next     = 1'b0;
                    ring_f_next    = 1'b0;
                    main_p_next    = 1'b1;
                    main_kind_next = KIND_RESP;
                    main_resp_next = RESP_CONNECT;
                    main_code_next = speed_code(speed_reg, 1'b0);
                end
                default: begin
                    cmd_f_next     = 1'b1;
                    conn_f_next    = 1'b0;
                    ring_f_next    = 1'b0;
                    main_p_next    = 1'b1;
                    main_kind_next = KIND_HANGUP;
                end
            endcase
        end

        if (cmd.decode) begin
            // executed line becomes the previous line, the other bank takes new input
            prev_bank_next = xb;
            cur_bank_next  = !xb;
            prev_pfx_next  = xp;
            prev_len_next  = xl;
            prev_atf_next  = is_atf;
            len_next       = '0;
            main_p_next    = 1'b1;
            main_kind_next = KIND_RESP;
            main_byte_next = '0;
            main_resp_next = RESP_OK;
            main_code_next = CODE_NONE;
            if (is_atz) begin
                echo_f_next = 1'b1; wordy_f_next = 1'b1; auto_f_next = 1'b0;
            end else if (is_atf) begin
                if (prev_atf_reg) begin
                    echo_f_next = 1'b1; wordy_f_next = 1'b1; auto_f_next = 1'b0;
                end else begin
                    main_resp_next = RESP_VERIFY;
                end
            end else if (is_ata) begin
                if (ring_f_reg) begin
                    conn_f_next    = 1'b1;
                    cmd_f_next     = 1'b0;
                    ring_f_next    = 1'b0;
                    main_resp_next = RESP_CONNECT;
                    main_code_next = speed_code(speed_reg, 1'b1);
                end else begin
                    cmd_f_next     = 1'b1;
                    conn_f_next    = 1'b0;
                    ring_f_next    = 1'b0;
                    main_kind_next = KIND_HANGUP;
                end
            end else if (is_atdo) begin
                if (conn_f_reg) begin
                    cmd_f_next  = 1'b0;
                    main_p_next = 1'b0;
                end else begin
                    main_resp_next = RESP_ERROR;
                    main_code_next = CODE_ERROR;
                end
            end else if (st_dtsp || st_dsp || st_atdt) begin
                main_p_next   = 1'b0;
                prev_len_next = '0;
                prev_atf_next = 1'b0;
                dial_idx_next = st_dtsp ? LW'(5) : LW'(4);
                dial_end_next = xl;
            end else if (is_ath) begin
                cmd_f_next     = 1'b1;
                conn_f_next    = 1'b0;
                ring_f_next    = 1'b0;
                main_kind_next = KIND_HANGUP;
            end else if (st_at) begin
                stat.need_scan = 1'b1;
                scan_idx_next  = '0;
                b1_next = '0; b2_next = '0;
                e0_next = 1'b0; e1_next = 1'b0; q0_next = 1'b0;
                v0_next = 1'b0; v1_next = 1'b0;
                s0_next = 1'b0; dig_next = 1'b0; nz_next = 1'b0;
            end else begin
                main_resp_next = RESP_ERROR;
                main_code_next = CODE_ERROR;
            end
        end

        if (cmd.scan) begin
            if (scan_idx_reg < prev_len_reg) begin
                scan_idx_next = scan_idx_reg + LW'(1);
                scan_v_next   = 1'b1;
            end
            if (scan_v_reg) begin
                b2_next = b1_reg;
                b1_next = x;
                if (b1_reg == CH_E && x == CH_0) e0_next = 1'b1;
                if (b1_reg == CH_E && x == CH_1) e1_next = 1'b1;
                if (b1_reg == CH_Q && x == CH_0) q0_next = 1'b1;
                if (b1_reg == CH_V && x == CH_0) v0_next = 1'b1;
                if (b1_reg == CH_V && x == CH_1) v1_next = 1'b1;
                // only the first s0= counts, then its run of digits
                if (!s0_reg && b2_reg == CH_S && b1_reg == CH_0 && x == CH_EQ) begin
                    s0_next  = 1'b1;
                    dig_next = 1'b1;
                end else if (dig_reg) begin
                    if (x >= CH_0 && x <= CH_9) begin
                        if (x != CH_0) nz_next = 1'b1;
                    end else begin
                        dig_next = 1'b0;
                    end
                end
            end
            if (scan_idx_reg == prev_len_reg && !scan_v_reg) begin
                stat.scan_done = 1'b1;
                if (e1_reg) echo_f_next = 1'b1;
                else if (e0_reg) echo_f_next = 1'b0;
                if (v1_reg) wordy_f_next = 1'b1;
                else if (q0_reg || v0_reg) wordy_f_next = 1'b0;
                if (s0_reg) auto_f_next = nz_reg;
            end
        end

        if (cmd.emit && out_free) begin
            m_user_next = KIND_ECHO;
            m_data_next = '0;
            m_last_next = 1'b0;
            if (echo_p_reg) begin
                echo_p_next     = 1'b0;
                m_valid_next    = 1'b1;
                m_data_next[7:0] = echo_byte_reg;
                m_last_next     = !ok_p_reg && !main_p_reg && !dial_p;
            end else if (ok_p_reg) begin
                ok_p_next    = 1'b0;
                m_valid_next = 1'b1;
                m_user_next  = KIND_RESP;
                m_data_next[10:8] = RESP_OK;
                m_last_next  = !main_p_reg && !dial_p;
            end else if (main_p_reg) begin
                main_p_next  = 1'b0;
                m_valid_next = 1'b1;
                m_user_next  = main_kind_reg;
                m_data_next[7:0]   = main_byte_reg;
                m_data_next[10:8]  = main_resp_reg;
                m_data_next[15:11] = main_code_reg;
                m_last_next  = !dial_p;
            end else if (dial_p && dial_rdy) begin
                dial_idx_next    = dial_idx_reg + LW'(1);
                m_valid_next     = 1'b1;
                m_user_next      = KIND_DIAL;
                m_data_next[7:0] = rdata_reg;
                m_last_next      = (dial_idx_reg + LW'(1) == dial_end_reg);
            end
            m_data_next[21:16] = {pulse_reg, carrier, ring_f_reg, conn_f_reg, cmd_f_reg,
                                  wordy_f_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= c;
        rdata_reg   <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= RST_LINE_SPEED;
            pol_reg   <= POL_INVERTED;
            esc_reg   <= RST_ESCAPE;
            bs_reg    <= RST_BACKSPACE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_SPEED: speed_reg <= cfg_data;
                REG_CARRIER:    pol_reg   <= cfg_data[1:0];
                REG_ESCAPE:     esc_reg   <= cfg_data[7:0];
                REG_BACKSPACE:  bs_reg    <= cfg_data[7:0];
                default:        speed_reg <= speed_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_bank_reg <= 1'b0;  prev_bank_reg <= 1'b1;
            len_reg      <= '0;    prev_len_reg  <= '0;
            prev_atf_reg <= 1'b0;  run_reg       <= '0;
            cmd_f_reg    <= 1'b1;  conn_f_reg    <= 1'b0;
            ring_f_reg   <= 1'b0;  echo_f_reg    <= 1'b1;
            wordy_f_reg  <= 1'b1;  auto_f_reg    <= 1'b0;
            a_slash_reg  <= 1'b0;  pulse_reg     <= 1'b0;
            echo_p_reg   <= 1'b0;  ok_p_reg      <= 1'b0;
            main_p_reg   <= 1'b0;
            dial_idx_reg <= '0;    dial_end_reg  <= '0;
            scan_idx_reg <= '0;    scan_v_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_bank_reg <= cur_bank_next;  prev_bank_reg <= prev_bank_next;
            len_reg      <= len_next;       prev_len_reg  <= prev_len_next;
            prev_atf_reg <= prev_atf_next;  run_reg       <= run_next;
            cmd_f_reg    <= cmd_f_next;     conn_f_reg    <= conn_f_next;
            ring_f_reg   <= ring_f_next;    echo_f_reg    <= echo_f_next;
            wordy_f_reg  <= wordy_f_next;   auto_f_reg    <= auto_f_next;
            a_slash_reg  <= a_slash_next;   pulse_reg     <= pulse_next;
            echo_p_reg   <= echo_p_next;    ok_p_reg      <= ok_p_next;
            main_p_reg   <= main_p_next;
            dial_idx_reg <= dial_idx_next;  dial_end_reg  <= dial_end_next;
            scan_idx_reg <= scan_idx_next;  scan_v_reg    <= scan_v_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_pfx_reg   <= cur_pfx_next;   prev_pfx_reg  <= prev_pfx_next;
        op_reg        <= op_next;        byte_reg      <= byte_next;
        echo_byte_reg <= echo_byte_next; main_byte_reg <= main_byte_next;
        main_kind_reg <= main_kind_next; main_resp_reg <= main_resp_next;
        main_code_reg <= main_code_next;
        b1_reg <= b1_next; b2_reg <= b2_next;
        e0_reg <= e0_next; e1_reg <= e1_next; q0_reg <= q0_next;
        v0_reg <= v0_next; v1_reg <= v1_next;
        s0_reg <= s0_next; dig_reg <= dig_next; nz_reg <= nz_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/at_command_modem_front_end.sv =====
// top level of the at command modem front end
// One input beat is processed at a time. A terminal byte or event first updates the
// mode and line state in the step state, a completed AT line is then decoded, and a
// line that sets E/Q/V/S0= flags a scan of the line memory at one byte per cycle
// through the single read port. Results then leave one per cycle as the output side
// takes them, dial-string bytes more slowly since each waits for a registered memory
// read. A plain echoed byte thus passes through accept, step, load of the echo and
// return to idle. The output register holds the last result while the next beat is
// accepted. The line memory keeps the typed line and the previous line in two banks
// that swap roles when a line runs, so no copying is done.
// Configuration writes are registered and must be made while the block is idle.
module at_command_modem_front_end #(
    parameter int LINE_DEPTH = atm_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [atm_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0]
    input  logic [atm_pkg::S_TUSER_W-1:0] s_tuser,   // op[1:0]
    // result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_byte[7:0], response[10:8], numeric_code[15:11], verbose_mode[16],
    // in_command_mode[17], is_connected[18], is_ringing[19], carrier_level[20],
    // ring_pulse[21], zero[23:22]
    output logic [atm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [atm_pkg::M_TUSER_W-1:0] m_tuser,   // kind[2:0]
    output logic                          m_tlast,   // last_of_run
    // configuration writes
    input  logic                          cfg_we,
    input  logic [atm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atm_pkg::CFG_W-1:0]     cfg_data
);
    import atm_pkg::*;

    atm_cmd_t  cmd;
    atm_stat_t stat;

    // sequencer
    atm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // line memory, flags and output register
    atm_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // one item at a time: no second beat right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back to back cycles");

    // ring pulse only rides on a ring response
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tuser == KIND_RESP && m_tdata[10:8] == RESP_RING)
        else $error("ring pulse on a non-ring beat");

    // dial bytes only come from command mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DIAL |-> m_tdata[17])
        else $error("dial byte outside command mode");

    // network bytes only while online in data mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_NET |-> !m_tdata[17] && m_tdata[18])
        else $error("network byte while not online");

endmodule

// ===== tb/tb_at_command_modem_front_end.sv =====
// self-checking testbench of the at command modem front end: directed table, then random traffic
module tb_at_command_modem_front_end;
    import atm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LD       = LINE_DEPTH_DEF;
    localparam int RUN_MAX  = 48;
    localparam int PHASES   = 8;
    localparam int PER_PHASE = 50;
    localparam int SETTLE   = 200;

    // hayes codes for connect, by line speed
    localparam logic [4:0] CODE_C38400   = 5'd28;
    localparam logic [4:0] CODE_C19200_A = 5'd14;
    localparam logic [4:0] CODE_C19200_D = 5'd15;
    localparam logic [4:0] CODE_C14400   = 5'd13;
    localparam logic [4:0] CODE_C9600    = 5'd12;
    localparam logic [4:0] CODE_C4800    = 5'd11;
    localparam logic [4:0] CODE_C2400    = 5'd10;
    localparam logic [4:0] CODE_C1200    = 5'd5;
    localparam logic [4:0] CODE_CONNECT  = 5'd1;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    at_command_modem_front_end dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one predicted modem result, with an optional typed-in check on the run's last beat
    typedef struct {
        kind_t      kind;
        logic [7:0] b;
        resp_t      resp;
        logic [4:0] code;
        logic       last;
        logic       verbose;
        logic       cmd;
        logic       conn;
        logic       ring;
        logic       carrier;
        logic       pulse;
        bit         typed;
        kind_t      t_kind;
        resp_t      t_resp;
        logic [4:0] t_code;
    } modem_res_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] b;
        resp_t      resp;
        logic [4:0] code;
    } run_res_t;

    typedef struct {
        op_t        op;
        logic [7:0] b;
        bit         typed;
        kind_t      k;
        resp_t      r;
        logic [4:0] c;
    } dir_row_t;

    modem_res_t modem_exp_q[$];
    run_res_t   run_q[$];
    int         mismatches = 0;
    int         src_idle = 0;
    int         rcv_idle = 0;
    int         items_sent = 0;

    // shadow registers and modem state
    logic [19:0] cfg_speed = RST_LINE_SPEED;
    logic [1:0]  cfg_pol = POL_INVERTED;
    logic [7:0]  cfg_esc = RST_ESCAPE;
    logic [7:0]  cfg_bs = RST_BACKSPACE;
    logic [7:0]  cur_line [LD];
    logic [7:0]  prev_line [LD];
    int          cur_len = 0;
    int          prev_len = 0;
    int          esc_run = 0;
    bit          m_cmd = 1, m_conn = 0, m_ring = 0, m_echo = 1, m_wordy = 1, m_auto = 0;

    initial begin
        for (int i = 0; i < LD; i++) begin
            cur_line[i] = 8'h00;
            prev_line[i] = 8'h00;
        end
    end

    // ---------------- modem predictor ----------------

    function automatic void put(kind_t k, logic [7:0] b, resp_t r, logic [4:0] c);
        run_res_t e;
        e.kind = k; e.b = b; e.resp = r; e.code = c;
        // beats past the run limit are dropped
        if (run_q.size() < RUN_MAX) run_q.push_back(e);
    endfunction

    function automatic bit line_is(string s);
        if (cur_len != s.len()) return 0;
        for (int i = 0; i < s.len(); i++) if (cur_line[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic bit line_starts(string s);
        if (cur_len < s.len()) return 0;
        for (int i = 0; i < s.len(); i++) if (cur_line[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic int line_pos(string s);
        bit hit;
        for (int i = 0; i + s.len() <= cur_len; i++) begin
            hit = 1;
            for (int j = 0; j < s.len(); j++) if (cur_line[i+j] != s[j]) hit = 0;
            if (hit) return i;
        end
        return -1;
    endfunction

    function automatic logic [4:0] connect_code(bit answering);
        case (cfg_speed)
            20'd38400: return CODE_C38400;
            20'd19200: return answering ? CODE_C19200_A : CODE_C19200_D;
            20'd14400: return CODE_C14400;
            20'd9600:  return CODE_C9600;
            20'd4800:  return CODE_C4800;
            20'd2400:  return CODE_C2400;
            20'd1200:  return CODE_C1200;
            default:   return CODE_CONNECT;
        endcase
    endfunction

    function automatic void hang_up();
        m_cmd = 1; m_conn = 0; m_ring = 0;
        put(KIND_HANGUP, 8'h00, RESP_OK, CODE_NONE);
    endfunction

    function automatic void go_online(logic [4:0] c);
        m_conn = 1; m_cmd = 0; m_ring = 0;
        put(KIND_RESP, 8'h00, RESP_CONNECT, c);
    endfunction

    function automatic void answer_call();
        if (!m_ring) hang_up();
        else go_online(connect_code(1));
    endfunction

    function automatic void dial_from(int start);
        for (int i = start; i < cur_len; i++) put(KIND_DIAL, cur_line[i], RESP_OK, CODE_NONE);
        cur_len = 0;
    endfunction

    function automatic void set_flags();
        int  pos;
        int  i;
        bit  nz;
        if (line_pos("E0") >= 0) m_echo = 0;
        if (line_pos("E1") >= 0) m_echo = 1;
        if (line_pos("Q0") >= 0) m_wordy = 0;
        if (line_pos("V0") >= 0) m_wordy = 0;
        if (line_pos("V1") >= 0) m_wordy = 1;
        pos = line_pos("S0=");
        if (pos >= 0) begin
            i = pos + 3;
            nz = 0;
            while (i < cur_len && cur_line[i] >= CH_0 && cur_line[i] <= CH_9) begin
                if (cur_line[i] != CH_0) nz = 1;
                i++;
            end
            m_auto = nz;
        end
    endfunction

    function automatic void exec_line();
        if (line_is("AT/")) begin
            cur_line = prev_line;
            cur_len = prev_len;
        end
        if (line_is("ATZ")) begin
            m_echo = 1; m_wordy = 1; m_auto = 0;
            put(KIND_RESP, 8'h00, RESP_OK, CODE_NONE);
        end else if (line_is("AT&F")) begin
            if (prev_len == 4 && prev_line[0] == CH_A && prev_line[1] == CH_T &&
                prev_line[2] == CH_AMP && prev_line[3] == CH_F) begin
                m_echo = 1; m_wordy = 1; m_auto = 0;
                put(KIND_RESP, 8'h00, RESP_OK, CODE_NONE);
            end else begin
                put(KIND_RESP, 8'h00, RESP_VERIFY, CODE_NONE);
            end
        end else if (line_is("ATA")) begin
            answer_call();
        end else if (line_is("ATD") || line_is("ATO")) begin
            if (m_conn) m_cmd = 0;
            else put(KIND_RESP, 8'h00, RESP_ERROR, CODE_ERROR);
        end else if (line_starts("ATDT ") || line_starts("ATDP ") || line_starts("ATD ")) begin
            dial_from(line_pos(" ") + 1);
        end else if (line_starts("ATDT")) begin
            dial_from(4);
        end else if (line_is("ATH0") || line_is("ATH")) begin
            hang_up();
        end else if (line_starts("AT")) begin
            set_flags();
            put(KIND_RESP, 8'h00, RESP_OK, CODE_NONE);
        end else begin
            put(KIND_RESP, 8'h00, RESP_ERROR, CODE_ERROR);
        end
        prev_line = cur_line;
        prev_len = cur_len;
        cur_len = 0;
    endfunction

    function automatic bit esc_seen(logic [7:0] c);
        if (c == cfg_esc) esc_run++;
        else esc_run = 0;
        if (esc_run >= 3) begin
            esc_run = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic void command_char(logic [7:0] b);
        logic [7:0] c;
        c = (b >= CH_LA && b <= CH_LZ) ? b - CASE_OFS : b;
        if (m_echo) put(KIND_ECHO, c, RESP_OK, CODE_NONE);
        if (esc_seen(c)) put(KIND_RESP, 8'h00, RESP_OK, CODE_NONE);
        if (c == cfg_bs) begin
            if (cur_len > 0) cur_len--;
        end else if (c != CH_CR && c != CH_LF && c != cfg_esc) begin
            if (cur_len < LD) begin
                cur_line[cur_len] = c;
                cur_len++;
            end
            // a/ repeats the previous line at once
            if (cur_len >= 2 && cur_line[0] == CH_A && cur_line[1] == CH_SLASH) begin
                cur_line = prev_line;
                cur_len = prev_len;
                exec_line();
                cur_len = 0;
            end
        end else if (cur_len >= 2 && cur_line[0] == CH_A && cur_line[1] == CH_T) begin
            exec_line();
        end else begin
            cur_len = 0;
        end
    endfunction

    function automatic void data_char(logic [7:0] b);
        if (!m_conn) return;
        if (m_echo) put(KIND_ECHO, b, RESP_OK, CODE_NONE);
        if (esc_seen(b)) begin
            m_cmd = 1;
            put(KIND_RESP, 8'h00, RESP_OK, CODE_NONE);
        end
        if (!m_cmd) put(KIND_NET, b, RESP_OK, CODE_NONE);
    endfunction

    // runs one accepted beat through the model and queues its results
    function automatic void predict_modem(op_t op, logic [7:0] b, bit typed, kind_t tk,
                                          resp_t tr, logic [4:0] tc);
        bit         pulse;
        logic       carrier;
        modem_res_t e;
        pulse = 0;
        run_q.delete();
        case (op)
            OP_BYTE: begin
                if (m_cmd) command_char(b);
                else data_char(b);
            end
            OP_RING: begin
                m_ring = 1;
                if (m_auto) answer_call();
                else begin
                    put(KIND_RESP, 8'h00, RESP_RING, CODE_RING);
                    pulse = 1;
                end
            end
            OP_LINK_UP: go_online(connect_code(0));
            default: hang_up();
        endcase
        if (cfg_pol == POL_INVERTED) carrier = !m_conn;
        else if (cfg_pol == POL_DIRECT) carrier = m_conn;
        else carrier = 1'b0;
        for (int k = 0; k < run_q.size(); k++) begin
            e.kind = run_q[k].kind;
            e.b = run_q[k].b;
            e.resp = run_q[k].resp;
            e.code = run_q[k].code;
            e.last = (k == run_q.size() - 1);
            e.verbose = m_wordy;
            e.cmd = m_cmd;
            e.conn = m_conn;
            e.ring = m_ring;
            e.carrier = carrier;
            e.pulse = pulse;
            e.typed = typed && e.last;
            e.t_kind = tk;
            e.t_resp = tr;
            e.t_code = tc;
            modem_exp_q.push_back(e);
        end
    endfunction

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    modem_res_t got_exp;
    logic [27:0] want_bits;
    logic [27:0] got_bits;

    // each accepted result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_bits = {m_tdata, m_tuser, m_tlast};
            if (modem_exp_q.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, got %h", $time, got_bits);
            end else begin
                got_exp = modem_exp_q.pop_front();
                want_bits = {2'b00, got_exp.pulse, got_exp.carrier, got_exp.ring,
                             got_exp.conn, got_exp.cmd, got_exp.verbose, got_exp.code,
                             got_exp.resp, got_exp.b, got_exp.kind, got_exp.last};
                if (got_bits !== want_bits) begin
                    mismatches++;
                    $display("%0t: result mismatch, expected %h, got %h",
                             $time, want_bits, got_bits);
                end
                // hand-typed code from the directed table
                if (got_exp.typed && (m_tuser !== got_exp.t_kind ||
                    m_tdata[10:8] !== got_exp.t_resp || m_tdata[15:11] !== got_exp.t_code)) begin
                    mismatches++;
                    $display("%0t: table mismatch, expected kind %0d resp %0d code %0d, got %h",
                             $time, got_exp.t_kind, got_exp.t_resp, got_exp.t_code, got_bits);
                end
            end
        end
    end

    // ---------------- input side ----------------

    // one input beat; valid stays high across back-to-back beats
    task automatic send_beat(op_t op, logic [7:0] b, bit typed = 0, kind_t tk = KIND_ECHO,
                             resp_t tr = RESP_OK, logic [4:0] tc = CODE_NONE);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        predict_modem(op, b, typed, tk, tr, tc);
        items_sent++;
    endtask

    task automatic send_text(string s);
        logic [7:0] c;
        int         r;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            // random lower case to exercise the folding
            if (c >= CH_A && c <= CH_Z && $urandom_range(1)) c = c + CASE_OFS;
            send_beat(OP_BYTE, c);
        end
        r = $urandom_range(99);
        if (r < 70) send_beat(OP_BYTE, CH_CR);
        else if (r < 90) send_beat(OP_BYTE, CH_LF);
        else send_beat(OP_BYTE, cfg_esc);
    endtask

    // write enable drops for a cycle between writes
    task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LINE_SPEED: cfg_speed = val[19:0];
            REG_CARRIER:    cfg_pol = val[1:0];
            REG_ESCAPE:     cfg_esc = val[7:0];
            default:        cfg_bs = val[7:0];
        endcase
        @(posedge aclk);
    endtask

    // wait out all predicted beats, then let any silent work finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (modem_exp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    string cmd_lines [] = '{"ATZ", "AT&F", "AT&F", "ATA", "ATD", "ATO", "ATDT 5551", "ATDP 9",
                            "ATD 42", "ATDT77", "ATDT", "ATD ", "ATH", "ATH0", "ATE0", "ATE1",
                            "ATV0", "ATV1", "ATQ0", "ATQ1", "ATS0=1", "ATS0=0", "ATS0=007",
                            "ATI", "AT", "AT/", "A/", "XYZ", "ATE1V1S0=0", "AT&Q"};

    dir_row_t dir_tab [25] = '{
        '{OP_RING,      8'h00, 1, KIND_RESP,   RESP_RING,    CODE_RING},
        '{OP_LINK_DOWN, 8'h00, 1, KIND_HANGUP, RESP_OK,      CODE_NONE},
        '{OP_LINK_UP,   8'h00, 1, KIND_RESP,   RESP_CONNECT, CODE_C9600},
        '{OP_BYTE,      8'h78, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h2B, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h2B, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h2B, 1, KIND_RESP,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h61, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h74, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h68, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h0D, 1, KIND_HANGUP, RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h41, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h54, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h26, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h46, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h0D, 1, KIND_RESP,   RESP_VERIFY,  CODE_NONE},
        '{OP_BYTE,      8'h41, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h2F, 1, KIND_RESP,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h41, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h54, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h4F, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h0A, 1, KIND_RESP,   RESP_ERROR,   CODE_ERROR},
        '{OP_BYTE,      8'hFF, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h00, 0, KIND_ECHO,   RESP_OK,      CODE_NONE},
        '{OP_BYTE,      8'h0D, 0, KIND_ECHO,   RESP_OK,      CODE_NONE}
    };

    logic [19:0] speed_set [10] = '{20'd38400, 20'd19200, 20'd14400, 20'd9600, 20'd4800,
                                    20'd2400, 20'd1200, 20'd0, 20'd1000000, 20'd12345};

    initial begin
        string       s;
        int          r;
        int          goal;
        logic [7:0]  esc_v;
        logic [7:0]  bs_v;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings, no idling
        foreach (dir_tab[i])
            send_beat(dir_tab[i].op, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].k,
                      dir_tab[i].r, dir_tab[i].c);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // idling pattern of this phase
            case (p % 4)
                0: begin src_idle = 0;  rcv_idle = 0;  end
                1: begin src_idle = 88; rcv_idle = 0;  end
                2: begin src_idle = 0;  rcv_idle = 88; end
                default: begin src_idle = 30; rcv_idle = 30; end
            endcase
            // register settings, extremes among them
            case (p)
                1: begin esc_v = 8'h00; bs_v = 8'hFF; end
                2: begin esc_v = 8'hFF; bs_v = 8'h00; end
                5: begin esc_v = 8'h7E; bs_v = 8'h7F; end
                default: begin esc_v = RST_ESCAPE; bs_v = RST_BACKSPACE; end
            endcase
            cfg_write(REG_LINE_SPEED, {{(CFG_W-20){1'b0}}, speed_set[$urandom_range(9)]});
            cfg_write(REG_CARRIER, CFG_W'(p % 3));
            cfg_write(REG_ESCAPE, CFG_W'(esc_v));
            cfg_write(REG_BACKSPACE, CFG_W'(bs_v));

            goal = items_sent + PER_PHASE;
            while (items_sent < goal) begin
                r = $urandom_range(99);
                if (!m_cmd && m_conn) begin
                    // data mode: traffic to the network, now and then the escape run
                    if (r < 70) send_beat(OP_BYTE, 8'($urandom_range(255)));
                    else if (r < 85) repeat (3) send_beat(OP_BYTE, cfg_esc);
                    else send_beat(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)));
                end else if (r < 55) begin
                    s = cmd_lines[$urandom_range(cmd_lines.size() - 1)];
                    // dial digits or trailing junk on some lines
                    if ($urandom_range(3) == 0)
                        repeat ($urandom_range(6)) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
                    send_text(s);
                end else if (r < 65) begin
                    send_beat(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)));
                end else if (r < 75) begin
                    send_beat(OP_BYTE, 8'($urandom_range(255)));
                end else if (r < 80) begin
                    // overlong line hits the full-buffer drop
                    s = "AT";
                    repeat (LD + 4) s = {s, string'(8'(CH_A + $urandom_range(25)))};
                    send_text(s);
                end else if (r < 90) begin
                    send_beat(OP_BYTE, CH_A);
                    send_beat(OP_BYTE, CH_T);
                    send_beat(OP_BYTE, CH_Q);
                    send_beat(OP_BYTE, cfg_bs);
                    send_text("Z");
                end else begin
                    repeat (3) send_beat(OP_BYTE, cfg_esc);
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
